// File: sv/wmc_pkg.sv
// shared types and constants for the wiper motor controller
// no dependencies; used by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package wmc_pkg;

  // wiper state codes
  localparam logic [2:0] ST_PARKED   = 3'd0;
  localparam logic [2:0] ST_PARKING  = 3'd1;
  localparam logic [2:0] ST_SLOW     = 3'd2;
  localparam logic [2:0] ST_FAST     = 3'd3;
  localparam logic [2:0] ST_INTER_ON = 3'd4;
  localparam logic [2:0] ST_PAUSE    = 3'd5;
  localparam logic [2:0] ST_WASH     = 3'd6;
  localparam logic [2:0] ST_SWIPE    = 3'd7;

  // motor speed codes
  localparam logic [1:0] MOT_OFF  = 2'd0;
  localparam logic [1:0] MOT_SLOW = 2'd1;
  localparam logic [1:0] MOT_FAST = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_ENABLE      = 3'd0;
  localparam logic [2:0] CFG_PARK_LEVEL  = 3'd1;
  localparam logic [2:0] CFG_WASH_CYCLES = 3'd2;
  localparam logic [2:0] CFG_DELAYS_LOW  = 3'd3;
  localparam logic [2:0] CFG_DELAYS_HIGH = 3'd4;

  localparam logic [31:0] SPIN_OFF_MS   = 32'd100;
  localparam logic [14:0] DELAY_UNIT_MS = 15'd100;
  localparam logic [3:0]  INTER_FIRST   = 4'd3;
  localparam logic [3:0]  INTER_LAST    = 4'd8;
  localparam logic [4:0]  WASH_CNT_MAX  = 5'd31;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        park_raw;
    logic        wash_request;
    logic        swipe_request;
    logic        mode_valid;
    logic [2:0]  mode_state;
    logic [3:0]  mode_speed;
  } in_t;

  typedef struct packed {
    logic       slow_drive;
    logic       fast_drive;
    logic [2:0] wiper_state;
  } out_t;

  typedef struct packed {
    logic        enable;
    logic        park_active_level;
    logic [3:0]  wash_wipe_cycles;
    logic [23:0] inter_delays_low;
    logic [23:0] inter_delays_high;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  cur_state;
    logic [2:0]  state_before_wash;
    logic [1:0]  last_motor_speed;
    logic [1:0]  drive_bits;
    logic [31:0] motor_start_time;
    logic [31:0] pause_start_time;
    logic [14:0] pause_length;
    logic [4:0]  wash_pass_count;
    logic        park_seen_last;
    logic [3:0]  chosen_speed;
  } wstate_t;

  function automatic logic [1:0] motor_bits(input logic [1:0] speed);
    logic [1:0] bits;
    case (speed)
      MOT_FAST: bits = 2'b11;
      MOT_SLOW: bits = 2'b01;
      default:  bits = 2'b00;
    endcase
    return bits;
  endfunction

endpackage

`default_nettype wire

// File: sv/wmc_step.sv
// next-state logic for one update tick of the wiper controller
// depends on wmc_pkg; purely combinational, registered by the top level
`timescale 1ns / 1ps
`default_nettype none

module wmc_step (
  input  wire wmc_pkg::wstate_t st,
  input  wire wmc_pkg::cfg_t    cfg,
  input  wire wmc_pkg::in_t     beat,
  output wmc_pkg::wstate_t      st_nxt,
  output wmc_pkg::out_t         res
);

  logic        park;
  logic [2:0]  pl_idx;
  logic [7:0]  pl_byte;
  logic [1:0]  spd;
  logic        spun;
  logic [31:0] pause_elapsed;
  logic [2:0]  restore_state;

  always_comb begin
    park    = (beat.park_raw == cfg.park_active_level);
    st_nxt  = st;
    pl_idx  = 3'(st.chosen_speed - wmc_pkg::INTER_FIRST);
    pl_byte = 8'd0;
    spd     = wmc_pkg::MOT_OFF;
    spun    = 1'b0;
    pause_elapsed = beat.now_ms - st.pause_start_time;
    restore_state = st.state_before_wash;

    case (pl_idx)
      3'd0:    pl_byte = cfg.inter_delays_low[7:0];
      3'd1:    pl_byte = cfg.inter_delays_low[15:8];
      3'd2:    pl_byte = cfg.inter_delays_low[23:16];
      3'd3:    pl_byte = cfg.inter_delays_high[7:0];
      3'd4:    pl_byte = cfg.inter_delays_high[15:8];
      3'd5:    pl_byte = cfg.inter_delays_high[23:16];
      default: pl_byte = 8'd0;
    endcase

    if (!cfg.enable) begin
      st_nxt.last_motor_speed = wmc_pkg::MOT_OFF;
      st_nxt.drive_bits       = 2'b00;
    end else begin
      if (st.chosen_speed inside {[wmc_pkg::INTER_FIRST:wmc_pkg::INTER_LAST]}) begin
        st_nxt.pause_length = 15'(pl_byte) * wmc_pkg::DELAY_UNIT_MS;
      end

      if (beat.wash_request && st_nxt.cur_state != wmc_pkg::ST_WASH) begin
        st_nxt.state_before_wash = st_nxt.cur_state;
        st_nxt.cur_state         = wmc_pkg::ST_WASH;
      end
      if (beat.swipe_request && st_nxt.cur_state == wmc_pkg::ST_PARKED) begin
        st_nxt.cur_state = wmc_pkg::ST_SWIPE;
      end

      // motor speed picked by the state; parking may first start slow
      case (st_nxt.cur_state)
        wmc_pkg::ST_PARKING: spd = (st.drive_bits == 2'b00) ? wmc_pkg::MOT_SLOW
                                                              : st.last_motor_speed;
        wmc_pkg::ST_SLOW:     spd = wmc_pkg::MOT_SLOW;
        wmc_pkg::ST_FAST:     spd = wmc_pkg::MOT_FAST;
        wmc_pkg::ST_INTER_ON: spd = wmc_pkg::MOT_SLOW;
        wmc_pkg::ST_WASH:     spd = (st_nxt.state_before_wash == wmc_pkg::ST_FAST) ?
                                    wmc_pkg::MOT_FAST : wmc_pkg::MOT_SLOW;
        wmc_pkg::ST_SWIPE:    spd = wmc_pkg::MOT_FAST;
        default:              spd = wmc_pkg::MOT_OFF;
      endcase

      if (st_nxt.cur_state != wmc_pkg::ST_PARKING || st.drive_bits == 2'b00) begin
        if (spd != st.last_motor_speed && spd != wmc_pkg::MOT_OFF) begin
          st_nxt.motor_start_time = beat.now_ms;
        end
        st_nxt.last_motor_speed = spd;
        st_nxt.drive_bits       = wmc_pkg::motor_bits(spd);
      end

      spun = (beat.now_ms - st_nxt.motor_start_time) > wmc_pkg::SPIN_OFF_MS;

      case (st_nxt.state_before_wash)
        wmc_pkg::ST_PARKED: restore_state = wmc_pkg::ST_PARKING;
        wmc_pkg::ST_PAUSE:  restore_state = wmc_pkg::ST_INTER_ON;
        default:            restore_state = st_nxt.state_before_wash;
      endcase

      case (st_nxt.cur_state)
        wmc_pkg::ST_PARKING: begin
          if (park) begin
            st_nxt.last_motor_speed = wmc_pkg::MOT_OFF;
            st_nxt.drive_bits       = 2'b00;
            st_nxt.cur_state        = wmc_pkg::ST_PARKED;
            st_nxt.chosen_speed     = 4'd0;
          end
        end
        wmc_pkg::ST_INTER_ON: begin
          if (spun && park) begin
            st_nxt.pause_start_time = beat.now_ms;
            st_nxt.cur_state        = wmc_pkg::ST_PAUSE;
          end
        end
        wmc_pkg::ST_PAUSE: begin
          if (pause_elapsed > {17'd0, st_nxt.pause_length}) begin
            st_nxt.cur_state = wmc_pkg::ST_INTER_ON;
          end
        end
        wmc_pkg::ST_WASH: begin
          if (beat.wash_request) begin
            st_nxt.wash_pass_count = 5'd0;
            st_nxt.park_seen_last  = park;
          end else if (spun) begin
            if (park && !st.park_seen_last && st.wash_pass_count < wmc_pkg::WASH_CNT_MAX)
            begin
              st_nxt.wash_pass_count = st.wash_pass_count + 5'd1;
            end
            if (st_nxt.wash_pass_count >= {1'b0, cfg.wash_wipe_cycles}) begin
              st_nxt.cur_state = restore_state;
            end
            st_nxt.park_seen_last = park;
          end
        end
        wmc_pkg::ST_SWIPE: begin
          if (spun && park) begin
            st_nxt.cur_state = wmc_pkg::ST_PARKING;
          end
        end
        default: begin
        end
      endcase

      if (beat.mode_valid) begin
        st_nxt.cur_state    = beat.mode_state;
        st_nxt.chosen_speed = beat.mode_speed;
      end
    end

    res.slow_drive  = st_nxt.drive_bits[0];
    res.fast_drive  = st_nxt.drive_bits[1];
    res.wiper_state = st_nxt.cur_state;
  end

endmodule

`default_nettype wire

// File: sv/wiper_motor_controller_unit.sv
// wiper motor controller: channel handshakes, state and config registers
// depends on wmc_pkg and wmc_step
`timescale 1ns / 1ps
`default_nettype none

// Usage
// in_*  : one beat per update tick (timestamp, park switch, wash/swipe
//         requests, optional mode update). accepted when in_valid && !in_stall.
// out_* : one beat per tick with slow/fast drive bits and the new state,
//         accepted when out_valid && !out_stall.
// cfg_* : register writes (index 0..4), always ready; index 5..7 ignored.
//         write only while no tick is in flight.
// The result beat is registered and follows the taken input beat in the next
// cycle. The tick update is one pass through the next-state logic into the
// state and result registers; a tick can be taken every cycle unless stalled.
// While the result register holds a beat that is stalled, in_stall is high;
// a tick is taken in the same cycle the held result leaves.
// Synchronous reset puts the wiper parked with motor off, clears the config
// registers (block disabled) and empties the result register.
module wiper_motor_controller_unit (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire wmc_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output wmc_pkg::out_t      out_data,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire [2:0]          cfg_index,
  input  wire [23:0]         cfg_data
);

  wmc_pkg::cfg_t    cfg_r;
  wmc_pkg::wstate_t st_r;
  wmc_pkg::wstate_t st_nxt;
  wmc_pkg::out_t    res_nxt;
  wmc_pkg::out_t    out_r;
  logic             out_valid_r;
  logic             in_take;

  assign in_stall  = out_valid_r && out_stall;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  wmc_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .beat   (in_data),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wmc_pkg::CFG_ENABLE:      cfg_r.enable            <= cfg_data[0];
        wmc_pkg::CFG_PARK_LEVEL:  cfg_r.park_active_level <= cfg_data[0];
        wmc_pkg::CFG_WASH_CYCLES: cfg_r.wash_wipe_cycles  <= cfg_data[3:0];
        wmc_pkg::CFG_DELAYS_LOW:  cfg_r.inter_delays_low  <= cfg_data;
        wmc_pkg::CFG_DELAYS_HIGH: cfg_r.inter_delays_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.cur_state         <= wmc_pkg::ST_PARKED;
      st_r.state_before_wash <= wmc_pkg::ST_PARKED;
      st_r.last_motor_speed  <= wmc_pkg::MOT_OFF;
      st_r.drive_bits        <= 2'b00;
      st_r.motor_start_time  <= '0;
      st_r.pause_start_time  <= '0;
      st_r.pause_length      <= '0;
      st_r.wash_pass_count   <= '0;
      st_r.park_seen_last    <= 1'b0;
      st_r.chosen_speed      <= 4'd0;
    end else if (in_take) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/wmc_checker.sv
// port-level checks for the wiper motor controller, bound to the top level
// depends on wmc_pkg and wiper_motor_controller_unit
`timescale 1ns / 1ps
`default_nettype none

module wmc_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_stall,
  input wire                out_valid,
  input wire                out_stall,
  input wire wmc_pkg::out_t out_data
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // every accepted tick gives a result beat in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted tick produced no result beat");

  // input only blocked by a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // fast winding never without slow winding
  a_fast_slow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_data.fast_drive || out_data.slow_drive)
    else $error("fast drive without slow drive");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

endmodule

bind wiper_motor_controller_unit wmc_checker u_wmc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// File: tb/wiper_motor_controller_unit_tb.sv
// self-checking testbench for wiper_motor_controller_unit: directed wiper scenarios, then
// random phases under sender gaps and receiver stalls, checked against an in-bench model
// depends on wmc_pkg and the wiper_motor_controller_unit rtl
`timescale 1ns / 1ps

module wiper_motor_controller_unit_tb;

  localparam logic [3:0] SPD_PARK  = 4'd0;
  localparam logic [3:0] SPD_SLOW  = 4'd1;
  localparam logic [3:0] SPD_FAST  = 4'd2;
  localparam logic [3:0] SPD_SPARE = 4'd12;
  localparam logic [2:0] CFG_SPARE = 3'd5;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  wmc_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  wmc_pkg::out_t out_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [2:0]    cfg_index = '0;
  logic [23:0]   cfg_data = '0;

  // register mirror and wiper model state
  wmc_pkg::cfg_t regs = '0;
  logic [2:0]    w_state = wmc_pkg::ST_PARKED;
  logic [2:0]    w_prewash = wmc_pkg::ST_PARKED;
  logic [1:0]    w_motor = wmc_pkg::MOT_OFF;
  logic [1:0]    w_drv = 2'b00;
  logic [31:0]   w_t_start = '0;
  logic [31:0]   w_t_pause = '0;
  logic [14:0]   w_pause_ms = '0;
  logic [4:0]    w_passes = '0;
  logic          w_park_prev = 1'b0;
  logic [3:0]    w_speed_sel = SPD_PARK;

  wmc_pkg::out_t pending_drive_q[$];
  logic [31:0]   clock_ms = '0;
  int            ticks_sent = 0;
  int            burst_left = 0;
  int            errors = 0;
  int            stall_left = 0;
  logic [1:0]    stall_mode = '0;

  wiper_motor_controller_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void motor_set(input logic [1:0] spd, input logic [31:0] now);
    if (spd != w_motor && spd != wmc_pkg::MOT_OFF) w_t_start = now;
    w_motor = spd;
    w_drv = (spd == wmc_pkg::MOT_FAST) ? 2'b11 : (spd == wmc_pkg::MOT_SLOW) ? 2'b01 : 2'b00;
  endfunction

  function automatic logic spun_off(input logic [31:0] now);
    return (now - w_t_start) > wmc_pkg::SPIN_OFF_MS;
  endfunction

  // one update tick of the wiper state machine
  function automatic wmc_pkg::out_t wiper_next(input wmc_pkg::in_t t);
    logic          at_park;
    logic [3:0]    idx;
    logic [23:0]   bank;
    logic [7:0]    units;
    wmc_pkg::out_t r;
    at_park = (t.park_raw == regs.park_active_level);
    if (!regs.enable) begin
      motor_set(wmc_pkg::MOT_OFF, t.now_ms);
    end else begin
      if (w_speed_sel >= wmc_pkg::INTER_FIRST && w_speed_sel <= wmc_pkg::INTER_LAST) begin
        idx = w_speed_sel - wmc_pkg::INTER_FIRST;
        bank = (idx < 3) ? regs.inter_delays_low : regs.inter_delays_high;
        units = 8'(bank >> (8 * (idx % 3)));
        w_pause_ms = units * wmc_pkg::DELAY_UNIT_MS;
      end
      if (t.wash_request && w_state != wmc_pkg::ST_WASH) begin
        w_prewash = w_state;
        w_state = wmc_pkg::ST_WASH;
      end
      if (t.swipe_request && w_state == wmc_pkg::ST_PARKED) w_state = wmc_pkg::ST_SWIPE;
      case (w_state)
        wmc_pkg::ST_PARKED: motor_set(wmc_pkg::MOT_OFF, t.now_ms);
        wmc_pkg::ST_PARKING: begin
          if (w_drv == 2'b00) motor_set(wmc_pkg::MOT_SLOW, t.now_ms);
          if (at_park) begin
            motor_set(wmc_pkg::MOT_OFF, t.now_ms);
            w_state = wmc_pkg::ST_PARKED;
            w_speed_sel = SPD_PARK;
          end
        end
        wmc_pkg::ST_SLOW: motor_set(wmc_pkg::MOT_SLOW, t.now_ms);
        wmc_pkg::ST_FAST: motor_set(wmc_pkg::MOT_FAST, t.now_ms);
        wmc_pkg::ST_INTER_ON: begin
          motor_set(wmc_pkg::MOT_SLOW, t.now_ms);
          if (spun_off(t.now_ms) && at_park) begin
            w_t_pause = t.now_ms;
            w_state = wmc_pkg::ST_PAUSE;
          end
        end
        wmc_pkg::ST_PAUSE: begin
          motor_set(wmc_pkg::MOT_OFF, t.now_ms);
          if ((t.now_ms - w_t_pause) > {17'd0, w_pause_ms}) w_state = wmc_pkg::ST_INTER_ON;
        end
        wmc_pkg::ST_WASH: begin
          motor_set((w_prewash == wmc_pkg::ST_FAST) ? wmc_pkg::MOT_FAST : wmc_pkg::MOT_SLOW,
                    t.now_ms);
          if (t.wash_request) begin
            w_passes = '0;
            w_park_prev = at_park;
          end else if (spun_off(t.now_ms)) begin
            if (at_park && !w_park_prev && w_passes < wmc_pkg::WASH_CNT_MAX)
              w_passes = w_passes + 1'b1;
            if (w_passes >= {1'b0, regs.wash_wipe_cycles}) begin
              if (w_prewash == wmc_pkg::ST_PARKED) w_state = wmc_pkg::ST_PARKING;
              else if (w_prewash == wmc_pkg::ST_PAUSE) w_state = wmc_pkg::ST_INTER_ON;
              else w_state = w_prewash;
            end
            w_park_prev = at_park;
          end
        end
        default: begin
          motor_set(wmc_pkg::MOT_FAST, t.now_ms);
          if (spun_off(t.now_ms) && at_park) w_state = wmc_pkg::ST_PARKING;
        end
      endcase
      if (t.mode_valid) begin
        w_state = t.mode_state;
        w_speed_sel = t.mode_speed;
      end
    end
    r.slow_drive = w_drv[0];
    r.fast_drive = w_drv[1];
    r.wiper_state = w_state;
    return r;
  endfunction

  function automatic wmc_pkg::in_t mk_item(input int unsigned dt, input bit pk, input bit wash,
                                           input bit swipe, input bit mv,
                                           input logic [2:0] st, input logic [3:0] sp);
    wmc_pkg::in_t it;
    clock_ms = clock_ms + dt;
    it.now_ms = clock_ms;
    it.park_raw = pk;
    it.wash_request = wash;
    it.swipe_request = swipe;
    it.mode_valid = mv;
    it.mode_state = st;
    it.mode_speed = sp;
    return it;
  endfunction

  // plain tick, mode fields random but not applied
  function automatic wmc_pkg::in_t plain(input int unsigned dt, input bit pk);
    return mk_item(dt, pk, 1'b0, 1'b0, 1'b0, 3'($urandom), 4'($urandom));
  endfunction

  function automatic int unsigned next_dt();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(0, 80);
    if (p < 90) return $urandom_range(80, 400);
    if (p < 98) return $urandom_range(400, 30000);
    return $urandom;
  endfunction

  function automatic logic [3:0] pick_speed();
    if ($urandom_range(0, 9) < 6)
      return 4'($urandom_range(wmc_pkg::INTER_FIRST, wmc_pkg::INTER_LAST));
    return 4'($urandom);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_tick(input wmc_pkg::in_t item);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 120) : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    ticks_sent++;
    pending_drive_q.push_back(wiper_next(item));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      wmc_pkg::CFG_ENABLE:      regs.enable = val[0];
      wmc_pkg::CFG_PARK_LEVEL:  regs.park_active_level = val[0];
      wmc_pkg::CFG_WASH_CYCLES: regs.wash_wipe_cycles = val[3:0];
      wmc_pkg::CFG_DELAYS_LOW:  regs.inter_delays_low = val;
      wmc_pkg::CFG_DELAYS_HIGH: regs.inter_delays_high = val;
      default: ;
    endcase
  endtask

  // waits for the block to go idle, then writes all registers
  task automatic program_regs(input wmc_pkg::cfg_t c);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_drive_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    write_reg(wmc_pkg::CFG_ENABLE, 24'(c.enable));
    write_reg(wmc_pkg::CFG_PARK_LEVEL, 24'(c.park_active_level));
    write_reg(wmc_pkg::CFG_WASH_CYCLES, 24'(c.wash_wipe_cycles));
    write_reg(wmc_pkg::CFG_DELAYS_LOW, c.inter_delays_low);
    write_reg(wmc_pkg::CFG_DELAYS_HIGH, c.inter_delays_high);
    write_reg(CFG_SPARE + 3'($urandom_range(0, 2)), 24'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_disabled();
    send_tick(mk_item(10, 1'b1, 1'b1, 1'b1, 1'b1, wmc_pkg::ST_FAST, SPD_FAST));
    send_tick(mk_item(10, 1'b0, 1'b0, 1'b1, 1'b1, wmc_pkg::ST_SWIPE, 4'hF));
    send_tick(plain(10, 1'b1));
  endtask

  task automatic test_swipe();
    send_tick(mk_item(10, 1'b0, 1'b0, 1'b1, 1'b0, wmc_pkg::ST_PARKED, SPD_PARK));
    send_tick(plain(50, 1'b1));
    send_tick(plain(100, 1'b1));
    send_tick(plain(20, 1'b1));
  endtask

  task automatic test_run_modes();
    send_tick(mk_item(10, 1'b0, 1'b0, 1'b0, 1'b1, wmc_pkg::ST_SLOW, SPD_SLOW));
    send_tick(mk_item(10, 1'b0, 1'b0, 1'b0, 1'b1, wmc_pkg::ST_FAST, SPD_FAST));
    send_tick(mk_item(10, 1'b0, 1'b0, 1'b0, 1'b1, wmc_pkg::ST_PARKING, SPD_FAST));
    send_tick(plain(10, 1'b0));
    send_tick(plain(10, 1'b1));
  endtask

  task automatic test_intermittent();
    send_tick(mk_item(10, 1'b0, 1'b0, 1'b0, 1'b1, wmc_pkg::ST_INTER_ON, wmc_pkg::INTER_FIRST));
    send_tick(plain(150, 1'b1));
    send_tick(plain(60, 1'b0));
    send_tick(plain(60, 1'b0));
    send_tick(mk_item(10, 1'b0, 1'b0, 1'b0, 1'b1, wmc_pkg::ST_INTER_ON, wmc_pkg::INTER_LAST));
    send_tick(mk_item(10, 1'b0, 1'b0, 1'b0, 1'b1, wmc_pkg::ST_INTER_ON, SPD_SPARE));
    send_tick(plain(200, 1'b1));
    send_tick(mk_item(1000, 1'b0, 1'b0, 1'b0, 1'b1, wmc_pkg::ST_PARKED, SPD_PARK));
  endtask

  task automatic test_wash();
    send_tick(mk_item(10, 1'b0, 1'b1, 1'b0, 1'b0, wmc_pkg::ST_PARKED, SPD_PARK));
    send_tick(mk_item(10, 1'b1, 1'b1, 1'b0, 1'b0, wmc_pkg::ST_PARKED, SPD_PARK));
    send_tick(plain(30, 1'b0));
    send_tick(plain(100, 1'b1));
    send_tick(plain(50, 1'b0));
    send_tick(plain(50, 1'b1));
    send_tick(plain(50, 1'b0));
    send_tick(plain(50, 1'b1));
    send_tick(plain(50, 1'b1));
  endtask

  task automatic random_phase(input int n);
    int target;
    int kind;
    int k;
    int i;
    target = ticks_sent + n;
    while (ticks_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        send_tick(mk_item(next_dt(), 1'($urandom), 1'b0, 1'b0, 1'b1, 3'($urandom),
                          pick_speed()));
        k = $urandom_range(3, 12);
        for (i = 0; i < k; i++)
          send_tick(mk_item(next_dt(), 1'($urandom), $urandom_range(0, 19) == 0,
                            $urandom_range(0, 19) == 0, $urandom_range(0, 19) == 0,
                            3'($urandom), pick_speed()));
      end else if (kind < 45) begin
        send_tick(mk_item(next_dt(), 1'($urandom), 1'b0, 1'b0, 1'b1, wmc_pkg::ST_INTER_ON,
                          4'($urandom_range(wmc_pkg::INTER_FIRST, wmc_pkg::INTER_LAST))));
        k = $urandom_range(8, 30);
        for (i = 0; i < k; i++) send_tick(plain($urandom_range(20, 150), 1'($urandom)));
      end else if (kind < 65) begin
        k = $urandom_range(1, 4);
        for (i = 0; i < k; i++)
          send_tick(mk_item($urandom_range(5, 80), 1'($urandom), 1'b1, 1'($urandom), 1'b0,
                            3'($urandom), 4'($urandom)));
        k = 2 * regs.wash_wipe_cycles + 6;
        for (i = 0; i < k; i++) send_tick(plain($urandom_range(20, 150), 1'($urandom)));
      end else if (kind < 77) begin
        k = $urandom_range(1, 2);
        for (i = 0; i < k; i++)
          send_tick(mk_item($urandom_range(5, 80), 1'($urandom), 1'b0, 1'b1, 1'b0,
                            3'($urandom), 4'($urandom)));
        k = $urandom_range(4, 10);
        for (i = 0; i < k; i++) send_tick(plain($urandom_range(20, 150), 1'($urandom)));
      end else if (kind < 82) begin
        // wash held by mode updates with park edges every other tick, drives the count to the top
        for (i = 0; i < 70; i++)
          send_tick(mk_item($urandom_range(101, 200), i[0], 1'b0, 1'b0, 1'b1, wmc_pkg::ST_WASH,
                            4'($urandom)));
      end else begin
        k = $urandom_range(5, 15);
        for (i = 0; i < k; i++)
          send_tick(mk_item(next_dt(), 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                            3'($urandom), 4'($urandom)));
      end
    end
  endtask

  task automatic test_random();
    wmc_pkg::cfg_t c;
    int            p;
    for (p = 0; p < 8; p++) begin
      c.enable = ($urandom_range(0, 9) != 0);
      c.park_active_level = 1'($urandom);
      c.wash_wipe_cycles = 4'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        c.inter_delays_low = 24'($urandom);
        c.inter_delays_high = 24'($urandom);
      end else begin
        c.inter_delays_low = {8'($urandom_range(0, 8)), 8'($urandom_range(0, 8)),
                              8'($urandom_range(0, 8))};
        c.inter_delays_high = {8'($urandom_range(0, 8)), 8'($urandom_range(0, 8)),
                               8'($urandom_range(0, 8))};
      end
      if (p == 0) c = '{1'b1, 1'b0, 4'd0, 24'd0, 24'd0};
      if (p == 1) c = '{1'b1, 1'b1, 4'hF, 24'hFFFFFF, 24'hFFFFFF};
      if (p == 3) clock_ms = 32'hFFFF_F000;
      if (p == 4) c.enable = 1'b0;
      program_regs(c);
      random_phase((p == 4) ? 30 : 140);
    end
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    wmc_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_drive_q.size() == 0) begin
        report_mismatch("unexpected beat, state", out_data.wiper_state, 0);
      end else begin
        want = pending_drive_q.pop_front();
        if (out_data.slow_drive !== want.slow_drive)
          report_mismatch("slow_drive", out_data.slow_drive, want.slow_drive);
        if (out_data.fast_drive !== want.fast_drive)
          report_mismatch("fast_drive", out_data.fast_drive, want.fast_drive);
        if (out_data.wiper_state !== want.wiper_state)
          report_mismatch("wiper_state", out_data.wiper_state, want.wiper_state);
      end
    end
    if (stall_left == 0) begin
      stall_mode <= 2'($urandom);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_disabled();
    program_regs('{1'b1, 1'b1, 4'd2, 24'h030201, 24'hFF0500});
    test_swipe();
    test_run_modes();
    test_intermittent();
    test_wash();
    test_random();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_drive_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("wiper_motor_controller_unit_tb OK");
    end else begin
      $display("wiper_motor_controller_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("wiper_motor_controller_unit_tb NOT OK");
    $finish;
  end

endmodule
